// ===== design/hrbp_pkg.sv =====
// Package with types, character codes and result codes for the HTTP request byte parser.
package hrbp_pkg;

    localparam int unsigned FIELD_LIMIT_W   = 8;
    localparam int unsigned REQUEST_LIMIT_W = 16;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam int unsigned CFG_ADDR_W      = 1;
    localparam int unsigned S_TDATA_W       = 8;
    localparam int unsigned M_TDATA_W       = 32;

    localparam logic [FIELD_LIMIT_W-1:0]   FIELD_LIMIT_RST   = 8'd100;
    localparam logic [REQUEST_LIMIT_W-1:0] REQUEST_LIMIT_RST = 16'd4096;

    localparam logic [CFG_ADDR_W-1:0] REG_FIELD_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_REQUEST_LIMIT = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] GET_LEN  = 8'd3;
    localparam logic [7:0] POST_LEN = 8'd4;
    localparam logic [7:0] HTTP_LEN = 8'd5;
    localparam logic [7:0] HDR_IDX_MAX = 8'd254;
    localparam logic [15:0] POS_MAX = 16'hffff;

    typedef enum logic [2:0] {
        PART_NONE    = 3'd0,
        PART_METHOD  = 3'd1,
        PART_PATH    = 3'd2,
        PART_VERSION = 3'd3,
        PART_HEADER  = 3'd4,
        PART_BODY    = 3'd5
    } part_t;

    typedef enum logic [1:0] {
        METHOD_UNKNOWN = 2'd0,
        METHOD_GET     = 2'd1,
        METHOD_POST    = 2'd2
    } method_t;

    typedef enum logic [1:0] {
        STATUS_PARSING  = 2'd0,
        STATUS_COMPLETE = 2'd1,
        STATUS_REJECTED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_FIELD_LONG   = 3'd1,
        ERR_REQUEST_LONG = 3'd2,
        ERR_BAD_METHOD   = 3'd3,
        ERR_NO_SLASH     = 3'd4,
        ERR_BAD_PREFIX   = 3'd5,
        ERR_CR_NO_LF     = 3'd6
    } error_t;

    typedef enum logic [5:0] {
        PH_METHOD     = 6'b000001,
        PH_PATH       = 6'b000010,
        PH_VERSION    = 6'b000100,
        PH_VERSION_LF = 6'b001000,
        PH_HEADERS    = 6'b010000,
        PH_BODY       = 6'b100000
    } phase_t;

    typedef struct packed {
        error_t     error_code;
        status_t    status;
        method_t    method_code;
        logic [7:0] field_index;
        logic [7:0] echo_byte;
        part_t      part;
    } result_t;

    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h47;
            2'd1:    ch = 8'h45;
            default: ch = 8'h54;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h50;
            2'd1:    ch = 8'h4f;
            2'd2:    ch = 8'h53;
            default: ch = 8'h54;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] http_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            default: ch = 8'h2f;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/http_request_byte_parser.sv =====
// Top level of the HTTP request byte parser: tags each request byte with its field and index.
//
// Usage: request bytes enter on the s_ channel, one byte per transfer, with s_tuser
// set on the first byte of each request to restart the parser. Every input transfer
// produces exactly one result transfer on the m_ channel carrying the field tag, the
// byte itself, its index within the field, the method seen so far, the request
// status and an error code. The limits are set through the cfg_ write port while
// the block is idle: index 0 is the field limit, index 1 the request limit.
// An input transfer's result is registered in the output register. Throughput is one
// byte per cycle unless the receiver stalls; the per-byte parse is one pass of logic
// from the parser state and the input byte into the result register and the next state.
// When the receiver stalls, the result is held in the output register and s_tready
// falls unless m_tready is high in that cycle, so the stall reaches the sender
// without losing or repeating a transfer.
// After reset the output register is empty, the parser waits for the method and
// the limits return to 100 bytes per field and 4096 bytes per request.
module http_request_byte_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hrbp_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] first
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] part, [10:3] echo_byte, [18:11] field_index, [20:19] method_code,
    // [22:21] status, [25:23] error_code, [31:26] zero
    output logic [hrbp_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_we,
    input  logic [hrbp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hrbp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import hrbp_pkg::*;

    logic [7:0]  field_limit_reg;
    logic [15:0] request_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  field_count_reg, field_count_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic        get_match_reg, get_match_next;
    logic        post_match_reg, post_match_next;
    method_t     method_found_reg, method_found_next;
    logic        cr_pending_reg, cr_pending_next;
    logic        line_start_reg, line_start_next;
    status_t     final_status_reg, final_status_next;
    error_t      final_error_reg, final_error_next;

    logic        m_valid_reg, m_valid_next;
    result_t     result_reg, result_next;

    logic        accept;
    logic [7:0]  b;
    part_t       part;
    logic [7:0]  idx;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata[7:0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, result_reg};

    always_comb begin
        if (s_tuser) begin
            phase_next         = PH_METHOD;
            field_count_next   = '0;
            byte_position_next = '0;
            get_match_next     = 1'b1;
            post_match_next    = 1'b1;
            method_found_next  = METHOD_UNKNOWN;
            cr_pending_next    = 1'b0;
            line_start_next    = 1'b0;
            final_status_next  = STATUS_PARSING;
            final_error_next   = ERR_NONE;
        end else begin
            phase_next         = phase_reg;
            field_count_next   = field_count_reg;
            byte_position_next = byte_position_reg;
            get_match_next     = get_match_reg;
            post_match_next    = post_match_reg;
            method_found_next  = method_found_reg;
            cr_pending_next    = cr_pending_reg;
            line_start_next    = line_start_reg;
            final_status_next  = final_status_reg;
            final_error_next   = final_error_reg;
        end
        part = PART_NONE;
        idx  = '0;

        if (final_status_next == STATUS_PARSING) begin
            if (byte_position_next >= request_limit_reg) begin
                final_status_next = STATUS_REJECTED;
                final_error_next  = ERR_REQUEST_LONG;
            end else begin
                unique case (phase_next)
                    PH_METHOD: begin
                        if (field_count_next >= field_limit_reg) begin
                            final_status_next = STATUS_REJECTED;
                            final_error_next  = ERR_FIELD_LONG;
                        end else if (b == CH_SPACE) begin
                            if (get_match_next && field_count_next >= GET_LEN) begin
                                method_found_next = METHOD_GET;
                            end else if (post_match_next && field_count_next >= POST_LEN) begin
                                method_found_next = METHOD_POST;
                            end
                            if (method_found_next == METHOD_UNKNOWN) begin
                                final_status_next = STATUS_REJECTED;
                                final_error_next  = ERR_BAD_METHOD;
                            end else begin
                                phase_next       = PH_PATH;
                                field_count_next = '0;
                            end
                        end else begin
                            if (field_count_next < GET_LEN &&
                                b != get_char(field_count_next[1:0])) begin
                                get_match_next = 1'b0;
                            end
                            if (field_count_next < POST_LEN &&
                                b != post_char(field_count_next[1:0])) begin
                                post_match_next = 1'b0;
                            end
                            part             = PART_METHOD;
                            idx              = field_count_next;
                            field_count_next = field_count_next + 8'd1;
                        end
                    end
                    PH_PATH: begin
                        if (field_count_next == '0 && b != CH_SLASH) begin
                            final_status_next = STATUS_REJECTED;
                            final_error_next  = ERR_NO_SLASH;
                        end else if (field_count_next >= field_limit_reg) begin
                            final_status_next = STATUS_REJECTED;
                            final_error_next  = ERR_FIELD_LONG;
                        end else if (b == CH_SPACE || b == CH_QMARK) begin
                            phase_next       = PH_VERSION;
                            field_count_next = '0;
                        end else begin
                            part             = PART_PATH;
                            idx              = field_count_next;
                            field_count_next = field_count_next + 8'd1;
                        end
                    end
                    PH_VERSION: begin
                        if (field_count_next >= field_limit_reg) begin
                            final_status_next = STATUS_REJECTED;
                            final_error_next  = ERR_FIELD_LONG;
                        end else if (b == CH_CR) begin
                            phase_next = PH_VERSION_LF;
                        end else if (field_count_next < HTTP_LEN &&
                                     b != http_char(field_count_next[2:0])) begin
                            final_status_next = STATUS_REJECTED;
                            final_error_next  = ERR_BAD_PREFIX;
                        end else begin
                            part             = PART_VERSION;
                            idx              = field_count_next;
                            field_count_next = field_count_next + 8'd1;
                        end
                    end
                    PH_VERSION_LF: begin
                        if (b == CH_LF) begin
                            phase_next       = PH_HEADERS;
                            field_count_next = '0;
                            line_start_next  = 1'b1;
                            cr_pending_next  = 1'b0;
                        end else begin
                            final_status_next = STATUS_REJECTED;
                            final_error_next  = ERR_CR_NO_LF;
                        end
                    end
                    PH_HEADERS: begin
                        if (cr_pending_next && b == CH_LF) begin
                            cr_pending_next = 1'b0;
                            if (line_start_next) begin
                                phase_next = PH_BODY;
                            end else begin
                                line_start_next = 1'b1;
                            end
                            field_count_next = '0;
                        end else if (b == CH_CR) begin
                            cr_pending_next = 1'b1;
                        end else begin
                            cr_pending_next = 1'b0;
                            line_start_next = 1'b0;
                            part            = PART_HEADER;
                            idx             = field_count_next;
                            if (field_count_next < HDR_IDX_MAX) begin
                                field_count_next = field_count_next + 8'd1;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (field_count_next >= field_limit_reg) begin
                            final_status_next = STATUS_REJECTED;
                            final_error_next  = ERR_FIELD_LONG;
                        end else if (b == CH_NUL) begin
                            final_status_next = STATUS_COMPLETE;
                        end else begin
                            part             = PART_BODY;
                            idx              = field_count_next;
                            field_count_next = field_count_next + 8'd1;
                        end
                    end
                    default: begin
                        phase_next = PH_METHOD;
                    end
                endcase
            end
            if (byte_position_next < POS_MAX) begin
                byte_position_next = byte_position_next + 16'd1;
            end
        end

        result_next.part        = part;
        result_next.echo_byte   = b;
        result_next.field_index = idx;
        result_next.method_code = method_found_next;
        result_next.status      = final_status_next;
        result_next.error_code  = final_error_next;

        m_valid_next = accept || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_limit_reg   <= FIELD_LIMIT_RST;
            request_limit_reg <= REQUEST_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FIELD_LIMIT:   field_limit_reg   <= cfg_wdata[FIELD_LIMIT_W-1:0];
                REG_REQUEST_LIMIT: request_limit_reg <= cfg_wdata[REQUEST_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_METHOD;
            field_count_reg   <= '0;
            byte_position_reg <= '0;
            get_match_reg     <= 1'b1;
            post_match_reg    <= 1'b1;
            method_found_reg  <= METHOD_UNKNOWN;
            cr_pending_reg    <= 1'b0;
            line_start_reg    <= 1'b0;
            final_status_reg  <= STATUS_PARSING;
            final_error_reg   <= ERR_NONE;
            m_valid_reg       <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                phase_reg         <= phase_next;
                field_count_reg   <= field_count_next;
                byte_position_reg <= byte_position_next;
                get_match_reg     <= get_match_next;
                post_match_reg    <= post_match_next;
                method_found_reg  <= method_found_next;
                cr_pending_reg    <= cr_pending_next;
                line_start_reg    <= line_start_next;
                final_status_reg  <= final_status_next;
                final_error_reg   <= final_error_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    // A rejected request always carries a reason, and a live one never does.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.status == STATUS_REJECTED |->
            result_reg.error_code != ERR_NONE)
        else $error("rejected result without an error code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.status != STATUS_REJECTED |->
            result_reg.error_code == ERR_NONE)
        else $error("error code on a request that is not rejected");

    // Tagged bytes only come from a request that is still being parsed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.part != PART_NONE |->
            result_reg.status == STATUS_PARSING)
        else $error("tagged byte after the request finished");

    // Any field past the method implies the method was recognized.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.part != PART_NONE && result_reg.part != PART_METHOD |->
            result_reg.method_code != METHOD_UNKNOWN)
        else $error("field after the method without a known method");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("input transfer did not produce a result");

endmodule

// ===== tb/sv/http_request_byte_parser_tb.sv =====
// Testbench for the HTTP request byte parser: random and directed requests, checked against a tagger model.
import hrbp_pkg::*;

class http_tag_checker;
    string get_word  = "GET";
    string post_word = "POST";
    string http_word = "HTTP/";

    logic [FIELD_LIMIT_W-1:0]   field_limit;
    logic [REQUEST_LIMIT_W-1:0] request_limit;

    phase_t      stage;
    logic [7:0]  field_cnt;
    logic [15:0] position;
    bit          get_ok;
    bit          post_ok;
    bit          cr_seen;
    bit          at_line_start;
    method_t     method_seen;
    status_t     req_status;
    error_t      req_error;

    result_t     expected_tags[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
        field_limit   = FIELD_LIMIT_RST;
        request_limit = REQUEST_LIMIT_RST;
        mismatches    = 0;
        checked       = 0;
        restart();
    endfunction

    function void restart();
        stage         = PH_METHOD;
        field_cnt     = '0;
        position      = '0;
        get_ok        = 1'b1;
        post_ok       = 1'b1;
        cr_seen       = 1'b0;
        at_line_start = 1'b0;
        method_seen   = METHOD_UNKNOWN;
        req_status    = STATUS_PARSING;
        req_error     = ERR_NONE;
    endfunction

    function void set_limit(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        if (idx == REG_FIELD_LIMIT) begin
            field_limit = value[FIELD_LIMIT_W-1:0];
        end else if (idx == REG_REQUEST_LIMIT) begin
            request_limit = value[REQUEST_LIMIT_W-1:0];
        end
    endfunction

    function void refuse(input error_t code);
        req_status = STATUS_REJECTED;
        req_error  = code;
    endfunction

    function void note_byte(input logic [7:0] b, input logic first);
        result_t     r;
        logic [15:0] pos;
        r = '0;
        r.part = PART_NONE;
        if (first) begin
            restart();
        end
        if (req_status == STATUS_PARSING) begin
            pos = position;
            if (position != POS_MAX) begin
                position = position + 16'd1;
            end
            if (pos >= request_limit) begin
                refuse(ERR_REQUEST_LONG);
            end else begin
                case (stage)
                    PH_METHOD: begin
                        if (field_cnt >= field_limit) begin
                            refuse(ERR_FIELD_LONG);
                        end else if (b == CH_SPACE) begin
                            if (get_ok && field_cnt >= GET_LEN) begin
                                method_seen = METHOD_GET;
                            end else if (post_ok && field_cnt >= POST_LEN) begin
                                method_seen = METHOD_POST;
                            end
                            if (method_seen == METHOD_UNKNOWN) begin
                                refuse(ERR_BAD_METHOD);
                            end else begin
                                stage     = PH_PATH;
                                field_cnt = '0;
                            end
                        end else begin
                            if (field_cnt < GET_LEN && b != get_word[field_cnt]) begin
                                get_ok = 1'b0;
                            end
                            if (field_cnt < POST_LEN && b != post_word[field_cnt]) begin
                                post_ok = 1'b0;
                            end
                            r.part        = PART_METHOD;
                            r.field_index = field_cnt;
                            field_cnt     = field_cnt + 8'd1;
                        end
                    end
                    PH_PATH: begin
                        if (field_cnt == 8'd0 && b != CH_SLASH) begin
                            refuse(ERR_NO_SLASH);
                        end else if (field_cnt >= field_limit) begin
                            refuse(ERR_FIELD_LONG);
                        end else if (b == CH_SPACE || b == CH_QMARK) begin
                            stage     = PH_VERSION;
                            field_cnt = '0;
                        end else begin
                            r.part        = PART_PATH;
                            r.field_index = field_cnt;
                            field_cnt     = field_cnt + 8'd1;
                        end
                    end
                    PH_VERSION: begin
                        if (field_cnt >= field_limit) begin
                            refuse(ERR_FIELD_LONG);
                        end else if (b == CH_CR) begin
                            stage = PH_VERSION_LF;
                        end else if (field_cnt < HTTP_LEN && b != http_word[field_cnt]) begin
                            refuse(ERR_BAD_PREFIX);
                        end else begin
                            r.part        = PART_VERSION;
                            r.field_index = field_cnt;
                            field_cnt     = field_cnt + 8'd1;
                        end
                    end
                    PH_VERSION_LF: begin
                        if (b == CH_LF) begin
                            stage         = PH_HEADERS;
                            field_cnt     = '0;
                            at_line_start = 1'b1;
                            cr_seen       = 1'b0;
                        end else begin
                            refuse(ERR_CR_NO_LF);
                        end
                    end
                    PH_HEADERS: begin
                        if (cr_seen && b == CH_LF) begin
                            cr_seen = 1'b0;
                            if (at_line_start) begin
                                stage = PH_BODY;
                            end else begin
                                at_line_start = 1'b1;
                            end
                            field_cnt = '0;
                        end else if (b == CH_CR) begin
                            cr_seen = 1'b1;
                        end else begin
                            cr_seen       = 1'b0;
                            at_line_start = 1'b0;
                            r.part        = PART_HEADER;
                            r.field_index = field_cnt;
                            if (field_cnt < HDR_IDX_MAX) begin
                                field_cnt = field_cnt + 8'd1;
                            end
                        end
                    end
                    default: begin
                        if (field_cnt >= field_limit) begin
                            refuse(ERR_FIELD_LONG);
                        end else if (b == CH_NUL) begin
                            req_status = STATUS_COMPLETE;
                        end else begin
                            r.part        = PART_BODY;
                            r.field_index = field_cnt;
                            field_cnt     = field_cnt + 8'd1;
                        end
                    end
                endcase
            end
        end
        r.echo_byte   = b;
        r.method_code = method_seen;
        r.status      = req_status;
        r.error_code  = req_error;
        expected_tags.push_back(r);
    endfunction

    function void flag(input string what, input int unsigned want, input int unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("result %0d, %s: expected 0x%0h, got 0x%0h", checked, what, want, got);
        end
    endfunction

    function void check_tag(input logic [M_TDATA_W-1:0] word);
        result_t want;
        result_t got;
        got = word[$bits(result_t)-1:0];
        if (expected_tags.size() == 0) begin
            flag("transfer with nothing expected", 0, word);
        end else begin
            want = expected_tags.pop_front();
            if (got.part != want.part) flag("part", want.part, got.part);
            if (got.echo_byte != want.echo_byte) flag("echo_byte", want.echo_byte, got.echo_byte);
            if (got.field_index != want.field_index) begin
                flag("field_index", want.field_index, got.field_index);
            end
            if (got.method_code != want.method_code) begin
                flag("method_code", want.method_code, got.method_code);
            end
            if (got.status != want.status) flag("status", want.status, got.status);
            if (got.error_code != want.error_code) flag("error_code", want.error_code, got.error_code);
            if (word[M_TDATA_W-1:$bits(result_t)] != '0) begin
                flag("padding", 0, word[M_TDATA_W-1:$bits(result_t)]);
            end
        end
        checked++;
    endfunction

    function int unsigned open_tags();
        return expected_tags.size();
    endfunction
endclass

module http_request_byte_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT = 2000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    http_tag_checker tags;
    logic [7:0]      req_text[$];
    logic            req_first[$];
    int unsigned     req_counted;
    int unsigned     burst_left = 0;
    int unsigned     cur_field_limit = FIELD_LIMIT_RST;
    int unsigned     quiet_cycles = 0;

    http_request_byte_parser i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) tags.note_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) tags.check_tag(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("http_request_byte_parser_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : ready_pattern
        int unsigned style;
        int unsigned span;
        int unsigned tick;
        tick = 0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 160);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ((tick % 5) < 3);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (tags.open_tags() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_limits(input logic [7:0] fl, input logic [15:0] rl);
        logic [CFG_DATA_W-1:0] value;
        value = {8'($urandom_range(0, 255)), fl};
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FIELD_LIMIT;
        cfg_wdata <= value;
        tags.set_limit(REG_FIELD_LIMIT, value);
        @(posedge aclk);
        cfg_addr  <= REG_REQUEST_LIMIT;
        cfg_wdata <= rl;
        tags.set_limit(REG_REQUEST_LIMIT, rl);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_field_limit = fl;
    endtask

    task automatic push_byte(input logic [7:0] b);
        req_text.push_back(b);
        req_first.push_back(1'b0);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
        return v;
    endfunction

    task automatic push_random(input int unsigned n, input logic [7:0] a, input logic [7:0] b);
        int unsigned i;
        for (i = 0; i < n; i++) push_byte(byte_other_than(a, b));
    endtask

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 15) return $urandom_range(0, 5);
        if (r < 18) return cur_field_limit + $urandom_range(0, 2) - 1;
        return $urandom_range(0, cur_field_limit + 1);
    endfunction

    task automatic send_text();
        foreach (req_text[i]) send_byte(req_text[i], req_first[i]);
    endtask

    task automatic build_noise();
        int unsigned n;
        int unsigned i;
        req_text.delete();
        req_first.delete();
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
            req_text.push_back(8'($urandom_range(0, 255)));
            req_first.push_back(1'($urandom_range(0, 1)));
        end
        req_counted = n;
    endtask

    task automatic build_request();
        int unsigned fault;
        int unsigned n;
        int unsigned k;
        int unsigned lines;
        int unsigned start;
        req_text.delete();
        req_first.delete();
        fault = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;

        if (fault == 1) begin
            push_random(pick_len(), CH_SPACE, CH_SPACE);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_text("GET");
                4, 5, 6, 7: push_text("POST");
                8:          push_text("GETS");
                default:    push_text("POSTAL");
            endcase
        end
        push_byte(CH_SPACE);

        if (fault == 2) begin
            push_byte(byte_other_than(CH_SLASH, CH_SLASH));
        end else begin
            push_byte(CH_SLASH);
        end
        n = pick_len();
        if (n > 1) push_random(n - 1, CH_SPACE, CH_QMARK);
        push_byte(($urandom_range(0, 5) == 0) ? CH_QMARK : CH_SPACE);

        start = req_text.size();
        push_text("HTTP/");
        if (fault == 3) begin
            k = start + $urandom_range(0, 4);
            req_text[k] = byte_other_than(req_text[k], CH_CR);
        end
        n = pick_len();
        push_random((n > 5) ? n - 5 : $urandom_range(1, 3), CH_CR, CH_CR);
        push_byte(CH_CR);
        push_byte((fault == 4) ? byte_other_than(CH_LF, CH_LF) : CH_LF);

        lines = $urandom_range(0, 3);
        repeat (lines) begin
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(255, 300) : $urandom_range(1, 12);
            push_random(n, CH_CR, CH_CR);
            if ($urandom_range(0, 7) == 0) push_byte(CH_LF);
            if ($urandom_range(0, 7) == 0) begin
                push_byte(CH_CR);
                push_byte(byte_other_than(CH_LF, CH_CR));
            end
            push_crlf();
        end
        push_crlf();

        push_random(pick_len(), CH_NUL, CH_NUL);
        if (fault != 6) push_byte(CH_NUL);

        if (fault == 5) begin
            k = $urandom_range(1, req_text.size() - 1);
            while (req_text.size() > k) begin
                void'(req_text.pop_back());
                void'(req_first.pop_back());
            end
        end
        req_counted = req_text.size();
        if (fault == 7) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        end
        req_first[0] = ($urandom_range(0, 19) != 0);
    endtask

    task automatic run_requests(input int unsigned budget);
        int unsigned sent;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 14) == 0) begin
                build_noise();
            end else begin
                build_request();
            end
            send_text();
            sent += req_counted;
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    // One header line long enough to drive the header index into saturation.
    task automatic long_header_request();
        req_text.delete();
        req_first.delete();
        push_text("GET / HTTP/1.1");
        push_crlf();
        push_random(300, CH_CR, CH_CR);
        push_crlf();
        push_crlf();
        push_text("ok");
        push_byte(CH_NUL);
        req_first[0] = 1'b1;
        send_text();
    endtask

    initial begin : stimulus
        tags = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        req_text.delete();
        req_first.delete();
        push_text("GET / HTTP/1.1");
        push_crlf();
        push_crlf();
        push_text("A");
        push_byte(CH_NUL);
        push_byte(8'hff);
        push_text("X ");
        push_byte(CH_NUL);
        push_byte(CH_SPACE);
        req_first[0]  = 1'b1;
        req_first[21] = 1'b1;
        req_first[23] = 1'b1;
        send_text();

        run_requests(400);

        wait_drained();
        write_limits(8'd255, 16'd65535);
        run_requests(100);
        long_header_request();

        wait_drained();
        write_limits(8'd1, 16'd1);
        run_requests(100);

        wait_drained();
        write_limits(8'd4, 16'd60000);
        run_requests(250);

        wait_drained();
        write_limits(8'd8, 16'd40);
        run_requests(350);

        repeat (2) begin
            wait_drained();
            write_limits(8'($urandom_range(3, 30)), 16'($urandom_range(20, 300)));
            run_requests(250);
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (tags.mismatches == 0 && tags.open_tags() == 0) begin
            $display("http_request_byte_parser_tb: done, clean");
        end else begin
            $display("http_request_byte_parser_tb: done, errors");
        end
        $finish;
    end
endmodule
